[hw/rtl/itoa_pkg.sv]
package itoa_pkg;

  // Command codes of an input item.
  typedef enum logic [1:0] {
    CMD_CHAR = 2'd0,
    CMD_DEC  = 2'd1,
    CMD_HEX  = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_DEC_EMIT,
    ST_HEX_EMIT
  } state_t;

  localparam int unsigned ValueW   = 32;
  localparam int unsigned DecDigits = 10;
  localparam int unsigned HexDigits = ValueW / 4;
  localparam int unsigned BcdW     = DecDigits * 4;

  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChA     = 8'h41;
  localparam logic [7:0] ChMinus = 8'h2D;

  // Maps one digit (0..15) to its ASCII character, upper-case for A..F.
  function automatic logic [7:0] digit_to_ascii(input logic [3:0] d);
    logic [7:0] ch;
    if (d < 4'd10) begin
      ch = ChZero + {4'd0, d};
    end else begin
      ch = ChA + {4'd0, d} - 8'd10;
    end
    return ch;
  endfunction

endpackage

[hw/rtl/integer_to_ascii_formatter.sv]
// Channel   Ports                          Handshake
// input     in_cmd, in_value               accepted when start is high and busy is low
// result    out_ascii_char, out_last       one cycle each, marked by out_valid
//
// A character item gives its byte in the cycle after acceptance and leaves the block ready.
// A decimal item runs a bit-serial binary-to-BCD conversion
// (shift-and-add-3 over ten BCD digits) followed by a digit scan, one digit
// per cycle. A hex item is scanned one nibble per cycle.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops out_valid.
// Results cannot be stalled; each character is shown for exactly one cycle.
module integer_to_ascii_formatter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [31:0] in_value,
  output logic        out_valid,
  output logic [7:0]  out_ascii_char,
  output logic        out_last
);

  itoa_pkg::state_t state_r, state_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [31:0] bin_r, bin_nxt;
  logic [itoa_pkg::BcdW-1:0] bcd_r, bcd_nxt;
  logic        seen_r, seen_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_char_r, out_char_nxt;
  logic        out_last_r, out_last_nxt;

  logic [itoa_pkg::BcdW-1:0] bcd_adj;
  logic [3:0]  digit;
  logic        dig_last;
  logic        dig_emit;
  logic        accept;

  assign busy           = (state_r != itoa_pkg::ST_IDLE);
  assign accept         = start && !busy;
  assign out_valid      = out_valid_r;
  assign out_ascii_char = out_char_r;
  assign out_last       = out_last_r;

  // Add 3 to every BCD digit of 5 or more before the next doubling.
  always_comb begin
    for (int i = 0; i < itoa_pkg::DecDigits; i++) begin
      if (bcd_r[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd_r[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd_r[i*4 +: 4];
      end
    end
  end

  // The digit under scan, and whether it is printed (leading zeros are dropped).
  always_comb begin
    if (state_r == itoa_pkg::ST_DEC_EMIT) begin
      digit    = bcd_r[itoa_pkg::BcdW-1 -: 4];
      dig_last = (cnt_r == 5'(itoa_pkg::DecDigits - 1));
    end else begin
      digit    = bin_r[31:28];
      dig_last = (cnt_r == 5'(itoa_pkg::HexDigits - 1));
    end
    dig_emit = (digit != 4'd0) || seen_r || dig_last;
  end

  // Sequencer: next state and result register.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    bin_nxt       = bin_r;
    bcd_nxt       = bcd_r;
    seen_nxt      = seen_r;
    out_valid_nxt = 1'b0;
    out_char_nxt  = out_char_r;
    out_last_nxt  = 1'b0;
    unique case (state_r)
      itoa_pkg::ST_IDLE: begin
        if (accept) begin
          cnt_nxt  = '0;
          seen_nxt = 1'b0;
          bcd_nxt  = '0;
          unique case (itoa_pkg::cmd_t'(in_cmd))
            itoa_pkg::CMD_CHAR: begin
              out_valid_nxt = 1'b1;
              out_char_nxt  = in_value[7:0];
              out_last_nxt  = 1'b1;
            end
            itoa_pkg::CMD_DEC: begin
              state_nxt = itoa_pkg::ST_CONV;
              if (in_value[31]) begin
                // A minus sign leaves first; the magnitude is taken modulo 2^32.
                bin_nxt       = 32'd0 - in_value;
                out_valid_nxt = 1'b1;
                out_char_nxt  = itoa_pkg::ChMinus;
              end else begin
                bin_nxt = in_value;
              end
            end
            itoa_pkg::CMD_HEX: begin
              state_nxt = itoa_pkg::ST_HEX_EMIT;
              bin_nxt   = in_value;
            end
            default: begin
              // An unused command gives no characters.
            end
          endcase
        end
      end
      itoa_pkg::ST_CONV: begin
        // Shift one binary bit into the BCD register per cycle.
        bcd_nxt = {bcd_adj[itoa_pkg::BcdW-2:0], bin_r[31]};
        bin_nxt = {bin_r[30:0], 1'b0};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(itoa_pkg::ValueW - 1)) begin
          cnt_nxt   = '0;
          state_nxt = itoa_pkg::ST_DEC_EMIT;
        end
      end
      itoa_pkg::ST_DEC_EMIT, itoa_pkg::ST_HEX_EMIT: begin
        bcd_nxt       = {bcd_r[itoa_pkg::BcdW-5:0], 4'd0};
        bin_nxt       = {bin_r[27:0], 4'd0};
        cnt_nxt       = cnt_r + 5'd1;
        seen_nxt      = seen_r || dig_emit;
        out_valid_nxt = dig_emit;
        out_char_nxt  = itoa_pkg::digit_to_ascii(digit);
        out_last_nxt  = dig_last;
        if (dig_last) begin
          state_nxt = itoa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = itoa_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= itoa_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    bin_r      <= bin_nxt;
    bcd_r      <= bcd_nxt;
    seen_r     <= seen_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  // The final character of a run always coincides with the sequencer being idle.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (state_r == itoa_pkg::ST_IDLE))
    else $error("final character shown while sequencer still busy");

  // Nothing is printed while the conversion is under way, past its first cycle.
  a_conv_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == itoa_pkg::ST_CONV && $past(state_r) == itoa_pkg::ST_CONV) |-> !out_valid_r)
    else $error("character shown during BCD conversion");

  // The block only becomes busy after an accepted item.
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy raised without a start");

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  localparam int RandomItems   = 209;
  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles   = 60;

  // One pending formatting request.
  typedef struct {
    itoa_pkg::cmd_t cmd;
    logic [31:0]    value;
  } fmt_req_t;

  // One character expected on the result ports.
  typedef struct packed {
    logic [7:0] ascii_char;
    logic       last;
  } fmt_char_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_cmd = itoa_pkg::CMD_CHAR;
  logic [31:0] in_value = 32'd0;
  logic        out_valid;
  logic [7:0]  out_ascii_char;
  logic        out_last;

  fmt_req_t  pending_reqs[$];
  fmt_req_t  driven_req;
  fmt_char_t expected_chars[$];
  int        total_reqs = 0;
  int        reqs_sent = 0;
  int        mismatches = 0;
  int        quiet_cycles = 0;

  integer_to_ascii_formatter u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_cmd        (in_cmd),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ascii_char(out_ascii_char),
    .out_last      (out_last)
  );

  // Free-running clock, 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Works out the characters that one request should print.
  function automatic void predict_chars(fmt_req_t req);
    logic [31:0] mag;
    logic [31:0] radix;
    logic [31:0] rem;
    logic [3:0]  digits[12];
    logic [7:0]  ch;
    int          n;
    n = 0;
    if (req.cmd == itoa_pkg::CMD_CHAR) begin
      expected_chars.push_back('{ascii_char: req.value[7:0], last: 1'b1});
    end else if (req.cmd == itoa_pkg::CMD_DEC || req.cmd == itoa_pkg::CMD_HEX) begin
      mag = req.value;
      radix = (req.cmd == itoa_pkg::CMD_DEC) ? 32'd10 : 32'd16;
      // A negative decimal gets its sign first; the magnitude wraps mod 2^32.
      if (req.cmd == itoa_pkg::CMD_DEC && req.value[31]) begin
        expected_chars.push_back('{ascii_char: itoa_pkg::ChMinus, last: 1'b0});
        mag = 32'd0 - req.value;
      end
      do begin
        rem = mag % radix;
        mag = mag / radix;
        digits[n] = rem[3:0];
        n++;
      end while (mag != 32'd0);
      for (int k = n - 1; k >= 0; k--) begin
        if (digits[k] < 4'd10) begin
          ch = itoa_pkg::ChZero + {4'd0, digits[k]};
        end else begin
          ch = itoa_pkg::ChA + {4'd0, digits[k]} - 8'd10;
        end
        expected_chars.push_back('{ascii_char: ch, last: (k == 0)});
      end
    end
  endfunction

  // Sender idle rate for the current third of the run.
  function automatic int idle_percent();
    int third;
    third = (total_reqs > 0) ? (reqs_sent * 3) / total_reqs : 0;
    if (third == 0) begin
      return 28;
    end else if (third == 1) begin
      return 61;
    end
    return 0;
  endfunction

  // Values that favor digit-count boundaries, small numbers and sign edges.
  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    int          pow;
    case ($urandom_range(0, 5))
      0: v = $urandom;
      1: v = $urandom_range(0, 20);
      2: v = $urandom >> $urandom_range(0, 31);
      3: v = 32'd0 - $urandom_range(0, 20);
      4: begin
        v = 32'd1;
        pow = $urandom_range(0, 9);
        repeat (pow) v = v * 32'd10;
        v = v - $urandom_range(0, 1);
        if ($urandom_range(0, 1) == 1) begin
          v = 32'd0 - v;
        end
      end
      default: v = 32'h8000_0000 ^ ($urandom & 32'h0000_000F);
    endcase
    return v;
  endfunction

  function automatic void add_req(itoa_pkg::cmd_t cmd, logic [31:0] value);
    pending_reqs.push_back('{cmd: cmd, value: value});
  endfunction

  // Driver: presents pending items and predicts each one as it is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (start) begin
        predict_chars(driven_req);
        reqs_sent++;
      end
      if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= idle_percent()) begin
        driven_req = pending_reqs.pop_front();
        start    <= 1'b1;
        in_cmd   <= driven_req.cmd;
        in_value <= driven_req.value;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: checks each character against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected char expected none actual %h last %b",
                   $time, out_ascii_char, out_last);
          mismatches++;
        end else begin
          if (out_ascii_char !== expected_chars[0].ascii_char) begin
            $display("%0t: ascii_char expected %h actual %h",
                     $time, expected_chars[0].ascii_char, out_ascii_char);
            mismatches++;
          end
          if (out_last !== expected_chars[0].last) begin
            $display("%0t: last expected %b actual %b",
                     $time, expected_chars[0].last, out_last);
            mismatches++;
          end
          void'(expected_chars.pop_front());
        end
      end
      // Watchdog on cycles where neither channel moves an item.
      if (out_valid || (start && !busy)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("watchdog expired at %0t", $time);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int r;
    int made;
    itoa_pkg::cmd_t cmd;

    // Directed: byte extremes, sign and digit-count edges, unused commands, hex leading zeros.
    add_req(itoa_pkg::CMD_CHAR, 32'h0000_0000);
    add_req(itoa_pkg::CMD_CHAR, 32'h0000_00FF);
    add_req(itoa_pkg::CMD_CHAR, 32'hFFFF_FF7A);
    add_req(itoa_pkg::CMD_DEC, 32'd0);
    add_req(itoa_pkg::CMD_DEC, 32'd1);
    add_req(itoa_pkg::CMD_DEC, 32'd9);
    add_req(itoa_pkg::CMD_DEC, 32'd10);
    add_req(itoa_pkg::CMD_DEC, 32'hFFFF_FFFF);
    add_req(itoa_pkg::CMD_DEC, 32'hFFFF_FFF6);
    add_req(itoa_pkg::CMD_DEC, 32'd1000000000);
    add_req(itoa_pkg::CMD_DEC, 32'h7FFF_FFFF);
    add_req(itoa_pkg::CMD_DEC, 32'h8000_0000);
    add_req(itoa_pkg::CMD_NONE, 32'h0000_0000);
    add_req(itoa_pkg::CMD_NONE, 32'hFFFF_FFFF);
    add_req(itoa_pkg::CMD_HEX, 32'h0000_0000);
    add_req(itoa_pkg::CMD_HEX, 32'h0000_000F);
    add_req(itoa_pkg::CMD_HEX, 32'h0000_0010);
    add_req(itoa_pkg::CMD_HEX, 32'h0ABC_DEF0);
    add_req(itoa_pkg::CMD_HEX, 32'h1234_5678);
    add_req(itoa_pkg::CMD_HEX, 32'h8000_0000);
    add_req(itoa_pkg::CMD_HEX, 32'hFFFF_FFFF);

    // Random: mostly real commands, a few unused ones mixed in.
    made = 0;
    while (made < RandomItems) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        cmd = itoa_pkg::CMD_NONE;
      end else if (r < 30) begin
        cmd = itoa_pkg::CMD_CHAR;
      end else if (r < 65) begin
        cmd = itoa_pkg::CMD_DEC;
      end else begin
        cmd = itoa_pkg::CMD_HEX;
      end
      add_req(cmd, pick_value());
      made++;
    end
    total_reqs = pending_reqs.size();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (reqs_sent < total_reqs || expected_chars.size() > 0) begin
      @(posedge clk);
    end
    repeat (DrainCycles) @(posedge clk);

    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/itoa_pkg.sv
hw/rtl/integer_to_ascii_formatter.sv
tb/testbench.sv
